/* hdl/fdcr_pkg.sv */
// Shared types and constants for the framed decimal command receiver.
`default_nettype none
package fdcr_pkg;

  localparam int BUFFER_BYTES_DEF = 64;

  localparam logic [7:0] START_RESET = 8'h40;
  localparam logic [7:0] END_RESET   = 8'h25;
  localparam logic [7:0] CHAR_NL     = 8'h0A;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_PLUS   = 8'h2B;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_FLAG = 1'b1;

  localparam logic KIND_PACKET = 1'b0;
  localparam logic KIND_FLAG   = 1'b1;

  localparam logic CFG_START = 1'b0;
  localparam logic CFG_END   = 1'b1;

  localparam int OUT_DATA_W = 24;

  typedef enum logic [1:0] {
    FRAME_IDLE    = 2'd0,
    FRAME_PAYLOAD = 2'd1,
    FRAME_NEWLINE = 2'd2
  } frame_t;

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic        negative;
    logic [15:0] acc;
  } parse_t;

endpackage
`default_nettype wire

/* hdl/fdcr_parse.sv */
// One atoi step: folds a payload byte into the parse state.
`default_nettype none
module fdcr_parse (
  input  wire logic [7:0]     rx_byte,
  input  wire fdcr_pkg::parse_t cur,
  output fdcr_pkg::parse_t    nxt
);
  import fdcr_pkg::*;

  logic        blank;
  logic        digit;
  logic        sign;
  logic [15:0] acc_step;

  assign blank = (rx_byte == CHAR_SPACE) || ((rx_byte >= CHAR_TAB) && (rx_byte <= CHAR_CR));
  assign digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
  assign sign  = (rx_byte == CHAR_PLUS) || (rx_byte == CHAR_MINUS);
  // acc * 10 + digit, wrapping to 16 bits
  assign acc_step = (cur.acc << 3) + (cur.acc << 1) + {8'd0, rx_byte - CHAR_ZERO};

  always_comb begin
    nxt = cur;
    case (cur.phase)
      PH_SKIP: begin
        if (sign) begin
          nxt.negative = (rx_byte == CHAR_MINUS);
          nxt.phase    = PH_DIGITS;
        end else if (digit) begin
          nxt.phase = PH_DIGITS;
          nxt.acc   = acc_step;
        end else if (!blank) begin
          nxt.phase = PH_DONE;
        end
      end
      PH_DIGITS: begin
        if (digit) begin
          nxt.acc = acc_step;
        end else begin
          nxt.phase = PH_DONE;
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule
`default_nettype wire

/* hdl/fdcr_core.sv */
// Framing state machine, stored speed, pending flag and result register.
`default_nettype none
module fdcr_core #(
  parameter int BUFFER_BYTES = fdcr_pkg::BUFFER_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_op,
  input  wire logic [7:0]  in_byte,
  input  wire logic [7:0]  start_char,
  input  wire logic [7:0]  end_char,
  output logic             consume,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic             m_tuser,
  output logic [fdcr_pkg::OUT_DATA_W-1:0] m_tdata
);
  import fdcr_pkg::*;

  localparam int CountW    = $clog2(BUFFER_BYTES);
  localparam int KeepLimit = BUFFER_BYTES - 2;

  frame_t              frame, frame_next;
  logic [CountW-1:0]   count, count_next;
  parse_t              parse, parse_next, parse_step;
  logic [15:0]         speed, speed_next;
  logic                pending, pending_next;

  logic                out_load;
  logic                out_kind;
  logic                out_upd;
  logic                out_flag;
  logic                m_tvalid_next;
  logic                out_kind_r;
  logic [15:0]         out_speed_r;
  logic                out_upd_r;
  logic                out_flag_r;

  fdcr_parse u_parse (
    .rx_byte (in_byte),
    .cur     (parse),
    .nxt     (parse_step)
  );

  assign consume = in_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame   <= FRAME_IDLE;
      count   <= '0;
      parse   <= '{phase: PH_SKIP, negative: 1'b0, acc: 16'd0};
      speed   <= 16'd0;
      pending <= 1'b0;
    end else begin
      frame   <= frame_next;
      count   <= count_next;
      parse   <= parse_next;
      speed   <= speed_next;
      pending <= pending_next;
    end
  end

  always_comb begin
    frame_next   = frame;
    count_next   = count;
    parse_next   = parse;
    speed_next   = speed;
    pending_next = pending;
    out_load     = 1'b0;
    out_kind     = KIND_PACKET;
    out_upd      = 1'b0;
    out_flag     = 1'b0;
    if (consume) begin
      if (in_op == OP_FLAG) begin
        out_load     = 1'b1;
        out_kind     = KIND_FLAG;
        out_flag     = pending;
        pending_next = 1'b0;
      end else begin
        case (frame)
          FRAME_PAYLOAD: begin
            if (in_byte == end_char) begin
              frame_next = FRAME_NEWLINE;
            end else if (count < CountW'(KeepLimit)) begin
              count_next = count + 1'b1;
              parse_next = parse_step;
            end
          end
          FRAME_NEWLINE: begin
            if (in_byte == CHAR_NL) begin
              frame_next   = FRAME_IDLE;
              pending_next = 1'b1;
              out_load     = 1'b1;
              if (count != '0) begin
                speed_next = parse.negative ? (16'd0 - parse.acc) : parse.acc;
                out_upd    = 1'b1;
              end
            end
          end
          default: begin
            frame_next = FRAME_IDLE;
            if ((in_byte == start_char) && !pending) begin
              frame_next = FRAME_PAYLOAD;
              count_next = '0;
              parse_next = '{phase: PH_SKIP, negative: 1'b0, acc: 16'd0};
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    if (out_load) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end else begin
      m_tvalid_next = m_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind_r  <= out_kind;
      out_speed_r <= speed_next;
      out_upd_r   <= out_upd;
      out_flag_r  <= out_flag;
    end
  end

  assign m_tuser = out_kind_r;
  assign m_tdata = {{(OUT_DATA_W - 18){1'b0}}, out_flag_r, out_upd_r, out_speed_r};

endmodule
`default_nettype wire

/* hdl/framed_decimal_command_receiver.sv */
// Top level: input register, configuration registers and the receiver core.
//
//  channel  dir  handshake          payload
//  s        in   s_tvalid/s_tready  tuser: op; tdata: rx_byte
//  m        out  m_tvalid/m_tready  tuser: result_kind; tdata: speed, updated, ready
//  cfg      in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// One item per cycle unless the result is stalled; an accepted item is held in the input
// register, and its result is then loaded into the result register.
// Synchronous reset clears framing, parse state, speed, flag and both valids.
// A stalled result stalls the core; the input register still takes one item.
`default_nettype none
module framed_decimal_command_receiver #(
  parameter int BUFFER_BYTES = fdcr_pkg::BUFFER_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic        s_tuser,   // [0] op
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic             m_tuser,   // [0] result_kind
  output logic [fdcr_pkg::OUT_DATA_W-1:0] m_tdata,
  // [15:0] speed_value, [16] value_updated, [17] packet_ready, [23:18] zero
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data
);
  import fdcr_pkg::*;

  logic       in_valid, in_valid_next;
  logic       in_op;
  logic [7:0] in_byte;
  logic       consume;
  logic [7:0] start_char;
  logic [7:0] end_char;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_char <= START_RESET;
      end_char   <= END_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_START: start_char <= cfg_data;
        CFG_END:   end_char   <= cfg_data;
        default:   start_char <= start_char;
      endcase
    end
  end

  assign s_tready = !in_valid || consume;

  always_comb begin
    if (s_tvalid && s_tready) begin
      in_valid_next = 1'b1;
    end else if (consume) begin
      in_valid_next = 1'b0;
    end else begin
      in_valid_next = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= in_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op   <= s_tuser;
      in_byte <= s_tdata;
    end
  end

  fdcr_core #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_op      (in_op),
    .in_byte    (in_byte),
    .start_char (start_char),
    .end_char   (end_char),
    .consume    (consume),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tuser    (m_tuser),
    .m_tdata    (m_tdata)
  );

endmodule
`default_nettype wire

/* verif/tb_framed_decimal_command_receiver.sv */
// Testbench for framed_decimal_command_receiver: directed and random streams vs. a predictor.
module tb_framed_decimal_command_receiver;
  import fdcr_pkg::*;

  localparam int KEEP_LIMIT = BUFFER_BYTES_DEF - 2;

  typedef struct packed {
    logic        kind;
    logic [15:0] speed;
    logic        updated;
    logic        ready;
  } reply_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic                  s_tuser = OP_BYTE;  // [0] op
  logic [7:0]            s_tdata = 8'h00;    // [7:0] rx_byte
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic                  m_tuser;            // [0] result_kind
  logic [OUT_DATA_W-1:0] m_tdata;            // [15:0] speed, [16] updated, [17] ready
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_index = CFG_START;
  logic [7:0]            cfg_data = 8'h00;

  // predictor state
  logic [7:0]  start_c = START_RESET;
  logic [7:0]  end_c = END_RESET;
  frame_t      frame = FRAME_IDLE;
  int          kept = 0;
  phase_t      phase = PH_SKIP;
  logic        neg = 1'b0;
  logic [15:0] acc = 16'h0000;
  logic [15:0] speed = 16'h0000;
  logic        pending = 1'b0;

  reply_t reply_q[$];
  int     errors = 0;
  int     items_sent = 0;
  int     src_idle = 0;
  int     sink_stall = 0;

  framed_decimal_command_receiver i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall);
  end

  // atoi-style digit folding on one kept payload byte
  task automatic parse_char(input logic [7:0] c);
    logic digit;
    logic blank;
    digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    blank = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    if (phase == PH_SKIP && blank) begin
    end else if (phase == PH_SKIP && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
      neg = (c == CHAR_MINUS);
      phase = PH_DIGITS;
    end else begin
      if (phase == PH_SKIP) phase = digit ? PH_DIGITS : PH_DONE;
      if (phase == PH_DIGITS) begin
        if (digit) acc = acc * 16'd10 + 16'(c - CHAR_ZERO);
        else phase = PH_DONE;
      end
    end
  endtask

  task automatic advance_receiver(input logic op, input logic [7:0] c);
    reply_t r;
    if (op == OP_FLAG) begin
      r = '{KIND_FLAG, speed, 1'b0, pending};
      reply_q.push_back(r);
      pending = 1'b0;
    end else begin
      case (frame)
        FRAME_PAYLOAD: begin
          if (c == end_c) frame = FRAME_NEWLINE;
          else if (kept < KEEP_LIMIT) begin
            kept++;
            parse_char(c);
          end
        end
        FRAME_NEWLINE: begin
          if (c == CHAR_NL) begin
            frame = FRAME_IDLE;
            if (kept > 0) speed = neg ? 16'(-acc) : acc;
            pending = 1'b1;
            r = '{KIND_PACKET, speed, (kept > 0), 1'b0};
            reply_q.push_back(r);
          end
        end
        default: begin
          frame = FRAME_IDLE;
          if (c == start_c && !pending) begin
            frame = FRAME_PAYLOAD;
            kept = 0;
            phase = PH_SKIP;
            neg = 1'b0;
            acc = 16'h0000;
          end
        end
      endcase
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (reply_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind %0b data %0h",
                   $time, m_tuser, m_tdata);
          errors++;
        end else begin
          want = reply_q.pop_front();
          check_field("result_kind", want.kind, m_tuser);
          check_field("speed_value", want.speed, m_tdata[15:0]);
          check_field("value_updated", want.updated, m_tdata[16]);
          check_field("packet_ready", want.ready, m_tdata[17]);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_START) start_c = cfg_data;
        else end_c = cfg_data;
      end
      if (s_tvalid && s_tready) advance_receiver(s_tuser, s_tdata);
    end
  end

  task automatic send_item(input logic op, input logic [7:0] b);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(OP_BYTE, b);
  endtask

  task automatic read_flag();
    send_item(OP_FLAG, 8'($urandom_range(255)));
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // hold the sender until all results are back and the pipeline is empty
  task automatic settle();
    s_tvalid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_chars(input logic [7:0] sc, input logic [7:0] ec);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_START;
    cfg_data <= sc;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_END;
    cfg_data <= ec;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_blank();
    return ($urandom_range(5) == 0) ? CHAR_SPACE : CHAR_TAB + 8'($urandom_range(4));
  endfunction

  function automatic logic [7:0] pick_payload_byte();
    case ($urandom_range(5))
      0: return pick_blank();
      1: return ($urandom_range(1) != 0) ? CHAR_PLUS : CHAR_MINUS;
      2: return start_c;
      3: return 8'($urandom_range(255));
      default: return CHAR_ZERO + 8'($urandom_range(9));
    endcase
  endfunction

  task automatic random_packet(input bit long_payload);
    int n;
    if ($urandom_range(19) != 0) send_byte(start_c);
    else send_byte(8'($urandom_range(255)));
    repeat ($urandom_range(2)) send_byte(pick_blank());
    if ($urandom_range(1) != 0) send_byte(($urandom_range(1) != 0) ? CHAR_PLUS : CHAR_MINUS);
    n = ($urandom_range(7) == 0) ? $urandom_range(6, 12) : $urandom_range(5);
    repeat (n) send_byte(CHAR_ZERO + 8'($urandom_range(9)));
    repeat ($urandom_range(2)) send_byte(pick_payload_byte());
    if (long_payload) begin
      repeat ($urandom_range(55, 70)) send_byte(($urandom_range(3) != 0) ?
          CHAR_ZERO + 8'($urandom_range(9)) : pick_payload_byte());
    end
    if ($urandom_range(19) != 0) send_byte(end_c);
    if ($urandom_range(4) == 0) send_byte(8'($urandom_range(255)));
    if ($urandom_range(19) != 0) send_byte(CHAR_NL);
    if ($urandom_range(9) < 7) read_flag();
  endtask

  task automatic test_reset_read();
    read_flag();
  endtask

  task automatic test_framing();
    send_text("@\t-12%\n");
  endtask

  task automatic test_start_while_pending();
    send_text("@9%\n");
    read_flag();
  endtask

  task automatic test_empty_and_stray();
    send_text("@%Z");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CHAR_NL);
  endtask

  task automatic test_flag_mid_packet();
    read_flag();
    send_text("@+6");
    read_flag();
    send_text("5@%\n");
  endtask

  task automatic test_config_chars();
    read_flag();
    set_chars(8'h00, 8'hFF);
    send_byte(8'h00);
    send_text(" 7");
    send_byte(8'hFF);
    send_byte(CHAR_NL);
    read_flag();
    set_chars(8'h7E, 8'h7E);
    send_text("~-3~\n");
    read_flag();
  endtask

  task automatic test_random(input int idle, input int stall, input logic [7:0] sc,
                             input logic [7:0] ec, input int goal);
    int stop;
    set_chars(sc, ec);
    src_idle = idle;
    sink_stall = stall;
    stop = items_sent + goal;
    random_packet(1'b1);
    while (items_sent < stop) begin
      if ($urandom_range(9) < 8) random_packet($urandom_range(29) == 0);
      else send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
      if ($urandom_range(59) == 0) settle();
    end
    settle();
    src_idle = 0;
    sink_stall = 0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_read();
    test_framing();
    test_start_while_pending();
    test_empty_and_stray();
    test_flag_mid_packet();
    test_config_chars();
    test_random(0, 0, START_RESET, END_RESET, 370);
    test_random(64, 0, 8'h00, 8'hFF, 370);
    test_random(0, 64, 8'hFF, 8'h00, 370);
    test_random(12, 12, 8'($urandom_range(255)), 8'($urandom_range(255)), 370);
    settle();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("%0t: timeout", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
